@@ rtl/ile_pkg.sv @@
// Shared types, constants and codes for the indexed list engine.
package ile_pkg;

  // List geometry.
  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;

  // Field widths of the request and result transactions.
  localparam int FUNC_W  = 3;
  localparam int IDX_W   = 5;
  localparam int VALUE_W = 32;
  localparam int LEN_W   = 5;

  // The count register holds 0 to DEPTH inclusive.
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Width used when an index is compared with the count or a cell position.
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  // Operation codes carried in the func field.
  typedef enum logic [FUNC_W-1:0] {
    OP_FIND   = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_UPDATE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  // Request transaction.
  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [IDX_W-1:0]   index;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic               status;
    logic [VALUE_W-1:0] read_value;
    logic [LEN_W-1:0]   length;
  } out_item_t;

  // Action broadcast to every cell of the chain in the same cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_WRITE
  } cell_op_t;

  // Control bundle shared by all cells.
  typedef struct packed {
    cell_op_t             op;
    logic [CMP_W-1:0]     pos;
    logic [WORD_BITS-1:0] value;
  } cell_ctl_t;

endpackage

@@ rtl/indexed_list_engine_top.sv @@
// Top level of the indexed list engine: decode, count register, cell chain and result register.
//
//  Channel | Ports                        | Direction | Carries
//  request | in_valid, in_stall, in_data   | in        | func, index, value
//  result  | out_valid, out_stall, out_data| out       | status, read_value, length
//
// The cell chain, the count and the result register all update
// at the accepting edge, so the result is offered in the cycle straight after it.
// A new request is taken in every cycle while the result register is empty or being drained.
// The rate rests on the cell chain shifting every position at once, with one cell per list position.
// Reset clears the count and the result valid; stored words keep whatever they held.
// in_stall rises only while a result waits under out_stall.
module indexed_list_engine_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ile_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ile_pkg::out_item_t out_data
);

  localparam logic [ile_pkg::CNT_W-1:0] DEPTH_CNT = ile_pkg::CNT_W'(ile_pkg::DEPTH);

  logic                          accept;
  logic [ile_pkg::CNT_W-1:0]     count_r;
  logic [ile_pkg::CNT_W-1:0]     count_nxt;
  logic                          out_valid_r;
  ile_pkg::out_item_t            out_data_r;
  ile_pkg::out_item_t            result;
  ile_pkg::cell_ctl_t            ctl;
  logic [ile_pkg::CMP_W-1:0]     pos_ext;
  logic [ile_pkg::CMP_W-1:0]     cnt_ext;
  logic                          in_rng;
  logic                          full;
  logic                          err;
  logic                          find_ok;
  logic [ile_pkg::WORD_BITS-1:0] rd_sel;
  logic [ile_pkg::WORD_BITS-1:0] word_w [ile_pkg::DEPTH];
  logic [ile_pkg::WORD_BITS-1:0] rd_w   [ile_pkg::DEPTH];

  // A request passes whenever the result register can take its result.
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign pos_ext = ile_pkg::CMP_W'(in_data.index);
  assign cnt_ext = ile_pkg::CMP_W'(count_r);
  assign in_rng  = (pos_ext < cnt_ext);
  assign full    = (count_r == DEPTH_CNT);

  // Decode the request into a cell action, an error flag and the next count.
  always_comb begin
    ctl.op    = ile_pkg::CELL_HOLD;
    ctl.pos   = pos_ext;
    ctl.value = in_data.value[ile_pkg::WORD_BITS-1:0];
    err       = 1'b0;
    find_ok   = 1'b0;
    count_nxt = count_r;
    case (in_data.func)
      ile_pkg::OP_FIND: begin
        err     = ~in_rng;
        find_ok = in_rng;
      end
      ile_pkg::OP_INSERT: begin
        if ((pos_ext > cnt_ext) || full) begin
          err = 1'b1;
        end else begin
          ctl.op    = ile_pkg::CELL_INSERT;
          count_nxt = count_r + 1'b1;
        end
      end
      ile_pkg::OP_DELETE: begin
        if (in_rng) begin
          ctl.op    = ile_pkg::CELL_DELETE;
          count_nxt = count_r - 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      ile_pkg::OP_UPDATE: begin
        if (in_rng) begin
          ctl.op = ile_pkg::CELL_WRITE;
        end else begin
          err = 1'b1;
        end
      end
      ile_pkg::OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        err = 1'b1;
      end
    endcase
    if (!accept) begin
      ctl.op = ile_pkg::CELL_HOLD;
    end
  end

  // Chain of cells; each sees its neighbours' words for the shifts (zero below the first, its own word above the last).
  for (genvar g = 0; g < ile_pkg::DEPTH; g++) begin : g_cell
    logic [ile_pkg::WORD_BITS-1:0] prev_word;
    logic [ile_pkg::WORD_BITS-1:0] next_word;
    if (g == 0) begin : g_first
      assign prev_word = '0;
    end else begin : g_mid_lo
      assign prev_word = word_w[g-1];
    end
    if (g == ile_pkg::DEPTH - 1) begin : g_last
      assign next_word = word_w[g];
    end else begin : g_mid_hi
      assign next_word = word_w[g+1];
    end
    ile_cell u_cell (
      .clk       (clk),
      .cell_idx  (ile_pkg::CMP_W'(g)),
      .ctl       (ctl),
      .prev_word (prev_word),
      .next_word (next_word),
      .word      (word_w[g]),
      .rd_word   (rd_w[g])
    );
  end

  // Only the addressed cell drives a non-zero read word, so the read is an OR over the row.
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < ile_pkg::DEPTH; i++) begin
      rd_sel = rd_sel | rd_w[i];
    end
  end

  // Assemble the result transaction.
  always_comb begin
    result.status     = err;
    result.read_value = find_ok ? ile_pkg::VALUE_W'(rd_sel) : '0;
    result.length     = ile_pkg::LEN_W'(count_nxt);
  end

  // Count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // Result register: loads on every accepted request, empties when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/ile_cell.sv @@
// One storage cell of the list chain: holds a word and trades it with its neighbours.
module ile_cell (
  input  logic                          clk,
  input  logic [ile_pkg::CMP_W-1:0]     cell_idx,
  input  ile_pkg::cell_ctl_t            ctl,
  input  logic [ile_pkg::WORD_BITS-1:0] prev_word,
  input  logic [ile_pkg::WORD_BITS-1:0] next_word,
  output logic [ile_pkg::WORD_BITS-1:0] word,
  output logic [ile_pkg::WORD_BITS-1:0] rd_word
);

  logic [ile_pkg::WORD_BITS-1:0] word_r;
  logic [ile_pkg::WORD_BITS-1:0] word_nxt;
  logic                          at_pos;
  logic                          above_pos;

  assign at_pos    = (cell_idx == ctl.pos);
  assign above_pos = (cell_idx > ctl.pos);

  // Choose between holding, shifting up, shifting down and loading the new word.
  always_comb begin
    word_nxt = word_r;
    case (ctl.op)
      ile_pkg::CELL_INSERT: begin
        if (above_pos) begin
          word_nxt = prev_word;
        end else if (at_pos) begin
          word_nxt = ctl.value;
        end
      end
      ile_pkg::CELL_DELETE: begin
        if (above_pos || at_pos) begin
          word_nxt = next_word;
        end
      end
      ile_pkg::CELL_WRITE: begin
        if (at_pos) begin
          word_nxt = ctl.value;
        end
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  // The stored word carries no reset; only written positions are ever read.
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word    = word_r;
  assign rd_word = at_pos ? word_r : '0;

endmodule

@@ rtl/ile_checker.sv @@
// Port-level checks for the indexed list engine and their binding to the top level.
module ile_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input ile_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input ile_pkg::out_item_t out_data
);

  // A waiting result stays put while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Every accepted request yields a result in the following cycle.
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("no result one cycle after an accepted request");

  // A clear always succeeds and leaves an empty list.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.func == ile_pkg::OP_CLEAR)
      |=> (out_data.length == '0) && !out_data.status)
    else $error("clear did not empty the list");

  // The length never exceeds the list depth.
  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.length <= ile_pkg::LEN_W'(ile_pkg::DEPTH)))
    else $error("length beyond list depth");

  // Read data only comes with a successful operation.
  a_rd_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.read_value != '0) |-> !out_data.status)
    else $error("read data returned with an error status");

endmodule

bind indexed_list_engine_top ile_checker u_ile_checker (.*);
